// ===== hdl/csb_pkg.sv =====
// Shared types and constants for the clipped sprite blit core.
`default_nettype none
package csb_pkg;

   localparam int XY_W    = 16;   // camera-relative position
   localparam int ORG_W   = 8;    // hotspot inside sprite
   localparam int SIDE_W  = 9;    // sprite side and raster counters
   localparam int BASE_W  = 17;   // position minus hotspot, signed
   localparam int WW_W    = 11;   // window width register
   localparam int WH_W    = 10;   // window height register
   localparam int ADDR_W  = 19;   // frame buffer index
   localparam int DATA_W  = 16;   // pixel port width
   localparam int CSR_A_W = 2;

   localparam logic [WW_W-1:0] WW_RESET = WW_W'(80);
   localparam logic [WH_W-1:0] WH_RESET = WH_W'(25);
   localparam logic [WW_W-1:0] WW_MAX   = WW_W'(1024);
   localparam logic [WH_W-1:0] WH_MAX   = WH_W'(512);

   localparam logic [CSR_A_W-1:0] CSR_WINDOW_WIDTH  = CSR_A_W'(0);
   localparam logic [CSR_A_W-1:0] CSR_WINDOW_HEIGHT = CSR_A_W'(1);

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   // Clipped geometry of the current sprite, loaded by a start item.
   typedef struct packed {
      logic [BASE_W-1:0] base_x;    // two's complement
      logic [BASE_W-1:0] base_y;    // two's complement
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
      logic [SIDE_W-1:0] cut_left;
      logic [SIDE_W-1:0] col_end;   // width minus right cut
      logic [SIDE_W-1:0] cut_top;
      logic [SIDE_W-1:0] row_end;   // height minus bottom cut
   } csb_geom_type;

endpackage
`default_nettype wire

// ===== hdl/csb_clip.sv =====
// Start-item geometry: base position, clamped size and clip bounds.
`default_nettype none
module csb_clip #(
   parameter int MAX_SPRITE_SIDE = 256
) (
   input  wire logic signed [csb_pkg::XY_W-1:0]   pos_x,
   input  wire logic signed [csb_pkg::XY_W-1:0]   pos_y,
   input  wire logic        [csb_pkg::ORG_W-1:0]  origin_x,
   input  wire logic        [csb_pkg::ORG_W-1:0]  origin_y,
   input  wire logic        [csb_pkg::SIDE_W-1:0] sprite_width,
   input  wire logic        [csb_pkg::SIDE_W-1:0] sprite_height,
   input  wire logic        [csb_pkg::WW_W-1:0]   win_width,
   input  wire logic        [csb_pkg::WH_W-1:0]   win_height,
   output csb_pkg::csb_geom_type                  geom
);
   import csb_pkg::*;

   localparam int SIDE_MAXV = (1 << SIDE_W) - 1;
   localparam int SIDE_CAP  = (MAX_SPRITE_SIDE > SIDE_MAXV) ? SIDE_MAXV : MAX_SPRITE_SIDE;
   localparam logic [SIDE_W-1:0] SIDE_LIM = SIDE_W'(SIDE_CAP);
   localparam int CW = 20;

   // Clamp a signed cut into 0..lim.
   function automatic logic [SIDE_W-1:0] clamp_cut(input logic signed [CW-1:0] v,
                                                   input logic [SIDE_W-1:0] lim);
      logic signed [CW-1:0] lim_s;
      lim_s = $signed(CW'(lim));
      if (v < 0)
         return '0;
      else if (v > lim_s)
         return lim;
      else
         return v[SIDE_W-1:0];
   endfunction

   logic        [SIDE_W-1:0] w;
   logic        [SIDE_W-1:0] h;
   logic signed [BASE_W-1:0] bx;
   logic signed [BASE_W-1:0] by;
   logic signed [CW-1:0]     left_raw;
   logic signed [CW-1:0]     top_raw;
   logic signed [CW-1:0]     right_raw;
   logic signed [CW-1:0]     bottom_raw;
   logic        [SIDE_W-1:0] cut_right;
   logic        [SIDE_W-1:0] cut_bottom;

   always_comb begin
      w  = (sprite_width  > SIDE_LIM) ? SIDE_LIM : sprite_width;
      h  = (sprite_height > SIDE_LIM) ? SIDE_LIM : sprite_height;
      bx = BASE_W'(pos_x) - $signed(BASE_W'(origin_x));
      by = BASE_W'(pos_y) - $signed(BASE_W'(origin_y));

      left_raw   = -CW'(bx);
      top_raw    = -CW'(by);
      right_raw  = CW'(bx) + $signed(CW'(w)) - $signed(CW'(win_width));
      bottom_raw = CW'(by) + $signed(CW'(h)) - $signed(CW'(win_height));
      cut_right  = clamp_cut(right_raw, w);
      cut_bottom = clamp_cut(bottom_raw, h);

      geom.base_x   = bx;
      geom.base_y   = by;
      geom.width    = w;
      geom.height   = h;
      geom.cut_left = clamp_cut(left_raw, w);
      geom.col_end  = w - cut_right;
      geom.cut_top  = clamp_cut(top_raw, h);
      geom.row_end  = h - cut_bottom;
   end

endmodule
`default_nettype wire

// ===== hdl/clipped_sprite_blit_core.sv =====
// Clipped sprite blitter: start and pixel items in, frame buffer writes out.
`default_nettype none
// Takes one item per clock with no bubbles while rsp_ready holds; a start
// item loads the sprite geometry and clip bounds, and each pixel item that
// falls inside the window yields one write (address, pixel) via the clip
// stage (clip, form row/column) and then the result stage (stride multiply-add).
// The stride is the window width in force when the pixel leaves the clip stage;
// clipping uses the window size in force at the start item. Window registers are
// to be written only while no item is in flight; the block does not enforce this.
module clipped_sprite_blit_core #(
   parameter int MAX_SPRITE_SIDE = 256,
   parameter int PIXEL_BITS      = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_func,
   input  wire logic signed [csb_pkg::XY_W-1:0]    req_pos_x,
   input  wire logic signed [csb_pkg::XY_W-1:0]    req_pos_y,
   input  wire logic        [csb_pkg::ORG_W-1:0]   req_origin_x,
   input  wire logic        [csb_pkg::ORG_W-1:0]   req_origin_y,
   input  wire logic        [csb_pkg::SIDE_W-1:0]  req_sprite_width,
   input  wire logic        [csb_pkg::SIDE_W-1:0]  req_sprite_height,
   input  wire logic        [csb_pkg::DATA_W-1:0]  req_pixel_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic             [csb_pkg::ADDR_W-1:0]  rsp_write_address,
   output logic             [csb_pkg::DATA_W-1:0]  rsp_write_data,
   input  wire logic                               csr_we,
   input  wire logic        [csb_pkg::CSR_A_W-1:0] csr_index,
   input  wire logic        [csb_pkg::WW_W-1:0]    csr_wdata
);
   import csb_pkg::*;

   localparam int PROD_W   = ADDR_W + WW_W;
   // low PIXEL_BITS of the pixel are kept, never more than the port carries
   localparam int PIX_KEEP = (PIXEL_BITS < DATA_W) ? PIXEL_BITS : DATA_W;
   localparam logic [DATA_W-1:0] PIX_MASK = DATA_W'((64'(1) << PIX_KEEP) - 64'(1));

   // window registers
   logic [WW_W-1:0] ww_ff, ww_in;
   logic [WH_W-1:0] wh_ff, wh_in;
   logic [WW_W-1:0] eff_ww;
   logic [WH_W-1:0] eff_wh;

   // sprite state
   logic              active_ff, active_in;
   csb_geom_type      geom_ff, geom_in;
   csb_geom_type      geom_new;
   logic [SIDE_W-1:0] col_ff, col_in;
   logic [SIDE_W-1:0] row_ff, row_in;

   // clip stage
   logic                  a_valid_ff, a_valid_in;
   logic [ADDR_W-1:0]     a_sx_ff, a_sx_in;
   logic [ADDR_W-1:0]     a_sy_ff, a_sy_in;
   logic [DATA_W-1:0]     a_data_ff, a_data_in;

   // result stage
   logic                  o_valid_ff, o_valid_in;
   logic [ADDR_W-1:0]     o_addr_ff, o_addr_in;
   logic [DATA_W-1:0]     o_data_ff, o_data_in;

   logic              accept;
   logic              o_ready;
   logic              a_ready;
   logic              pixel_go;
   logic              in_window;
   logic              last_col;
   logic [PROD_W-1:0] prod;

   always_comb begin
      eff_ww = (ww_ff == '0) ? WW_W'(1) : ((ww_ff > WW_MAX) ? WW_MAX : ww_ff);
      eff_wh = (wh_ff == '0) ? WH_W'(1) : ((wh_ff > WH_MAX) ? WH_MAX : wh_ff);
   end

   csb_clip #(
      .MAX_SPRITE_SIDE (MAX_SPRITE_SIDE)
   ) u_clip (
      .pos_x         (req_pos_x),
      .pos_y         (req_pos_y),
      .origin_x      (req_origin_x),
      .origin_y      (req_origin_y),
      .sprite_width  (req_sprite_width),
      .sprite_height (req_sprite_height),
      .win_width     (eff_ww),
      .win_height    (eff_wh),
      .geom          (geom_new)
   );

   assign o_ready   = !o_valid_ff || rsp_ready;
   assign a_ready   = !a_valid_ff || o_ready;
   assign req_ready = a_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      ww_in = ww_ff;
      wh_in = wh_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_WIDTH:  ww_in = csr_wdata;
            CSR_WINDOW_HEIGHT: wh_in = csr_wdata[WH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pixel_go  = active_ff && (geom_ff.width != '0) && (row_ff < geom_ff.height);
      in_window = (col_ff >= geom_ff.cut_left) && (col_ff < geom_ff.col_end) &&
                  (row_ff >= geom_ff.cut_top) && (row_ff < geom_ff.row_end);
      last_col  = ({1'b0, col_ff} + (SIDE_W+1)'(1)) >= {1'b0, geom_ff.width};

      active_in = active_ff;
      geom_in   = geom_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (req_func == FUNC_START) begin
            active_in = 1'b1;
            geom_in   = geom_new;
            col_in    = '0;
            row_in    = '0;
         end else if (pixel_go) begin
            if (last_col) begin
               col_in = '0;
               row_in = row_ff + SIDE_W'(1);
            end else begin
               col_in = col_ff + SIDE_W'(1);
            end
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      a_sx_in    = a_sx_ff;
      a_sy_in    = a_sy_ff;
      a_data_in  = a_data_ff;
      if (a_ready) begin
         a_valid_in = accept && (req_func == FUNC_PIXEL) && pixel_go && in_window;
         a_sx_in    = ADDR_W'($signed(geom_ff.base_x)) + ADDR_W'(col_ff);
         a_sy_in    = ADDR_W'($signed(geom_ff.base_y)) + ADDR_W'(row_ff);
         a_data_in  = req_pixel_value & PIX_MASK;
      end
   end

   // row-major index, wrapped to the address width
   assign prod = PROD_W'(a_sy_ff) * PROD_W'(eff_ww);

   always_comb begin
      o_valid_in = o_valid_ff;
      o_addr_in  = o_addr_ff;
      o_data_in  = o_data_ff;
      if (o_ready) begin
         o_valid_in = a_valid_ff;
         o_addr_in  = prod[ADDR_W-1:0] + a_sx_ff;
         o_data_in  = a_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ww_ff      <= WW_RESET;
         wh_ff      <= WH_RESET;
         active_ff  <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         ww_ff      <= ww_in;
         wh_ff      <= wh_in;
         active_ff  <= active_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      geom_ff   <= geom_in;
      a_sx_ff   <= a_sx_in;
      a_sy_ff   <= a_sy_in;
      a_data_ff <= a_data_in;
      o_addr_ff <= o_addr_in;
      o_data_ff <= o_data_in;
   end

   assign rsp_valid         = o_valid_ff;
   assign rsp_write_address = o_addr_ff;
   assign rsp_write_data    = o_data_ff;

endmodule
`default_nettype wire
